[design/ist_pkg.sv]
// Shared constants, types and helpers for the integer set table.
package ist_pkg;

	localparam int CAPACITY = 256;
	localparam int VALUE_W  = 32;
	localparam int COUNT_W  = 9;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	localparam logic [1:0] MODE_ADD    = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_QUERY  = 2'd2;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic               we;
		logic [ADDR_W-1:0]  waddr;
		logic [VALUE_W-1:0] wdata;
		logic [ADDR_W-1:0]  raddr;
	} mem_req_t;

	// Low bits of the element count as reported on the result port.
	function automatic logic [COUNT_W-1:0] count_out(input logic [CNT_W-1:0] c);
		logic [CNT_W+COUNT_W-1:0] t;
		t = {{COUNT_W{1'b0}}, c};
		return t[COUNT_W-1:0];
	endfunction

endpackage

[design/ist_ram.sv]
// Simple dual-port synchronous RAM with registered read data.
module ist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/ist_ctrl.sv]
// Request sequencer: membership scan, append and shift-down on remove.
module ist_ctrl (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [1:0]                           mode,
	input  logic signed [ist_pkg::VALUE_W-1:0]   value,
	output logic                                 busy,
	output logic                                 done,
	output logic [1:0]                           status,
	output logic [ist_pkg::COUNT_W-1:0]          count,
	output ist_pkg::mem_req_t                    mem_req,
	input  logic [ist_pkg::VALUE_W-1:0]          rdata
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	state_t                          state_q;
	logic                            busy_q;
	logic                            done_q;
	ist_pkg::status_t                status_q;
	logic [ist_pkg::COUNT_W-1:0]     count_q;
	logic [ist_pkg::CNT_W-1:0]       cnt_q;
	logic [1:0]                      mode_q;
	logic [ist_pkg::VALUE_W-1:0]     value_q;
	logic [ist_pkg::CNT_W-1:0]       idx_q;
	logic [ist_pkg::CNT_W-1:0]       sh_q;
	logic                            vld_s1;
	logic [ist_pkg::CNT_W-1:0]       pos_s1;
	logic [ist_pkg::ADDR_W-1:0]      dst_s1;

	logic hit;
	logic scan_issue;
	logic scan_end;
	logic sh_issue;
	logic sh_end;
	logic full;

	always_comb begin
		hit        = vld_s1 && (rdata == value_q);
		scan_issue = !hit && (idx_q < cnt_q);
		scan_end   = hit || (!scan_issue && !vld_s1);
		sh_issue   = sh_q < cnt_q;
		sh_end     = !sh_issue && !vld_s1;
		full       = cnt_q == ist_pkg::CNT_W'(ist_pkg::CAPACITY);
	end

	always_comb begin
		mem_req.we    = 1'b0;
		mem_req.waddr = cnt_q[ist_pkg::ADDR_W-1:0];
		mem_req.wdata = value_q;
		mem_req.raddr = idx_q[ist_pkg::ADDR_W-1:0];
		case (state_q)
			S_SCAN: begin
				mem_req.we = scan_end && (mode_q == ist_pkg::MODE_ADD) && !hit && !full;
			end
			S_SHIFT: begin
				// move the entry read last cycle one place down
				mem_req.we    = vld_s1;
				mem_req.waddr = dst_s1;
				mem_req.wdata = rdata;
				mem_req.raddr = sh_q[ist_pkg::ADDR_W-1:0];
			end
			default: begin
				mem_req.we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			busy_q   <= 1'b0;
			done_q   <= 1'b0;
			status_q <= ist_pkg::ST_OK;
			count_q  <= '0;
			cnt_q    <= '0;
			mode_q   <= '0;
			value_q  <= '0;
			idx_q    <= '0;
			sh_q     <= '0;
			vld_s1   <= 1'b0;
			pos_s1   <= '0;
			dst_s1   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						mode_q  <= mode;
						value_q <= value;
						idx_q   <= '0;
						vld_s1  <= 1'b0;
						busy_q  <= 1'b1;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					vld_s1 <= scan_issue;
					pos_s1 <= idx_q;
					if (scan_issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_end) begin
						// drop any read still in flight
						vld_s1 <= 1'b0;
						state_q <= S_IDLE;
						busy_q  <= 1'b0;
						done_q  <= 1'b1;
						count_q <= ist_pkg::count_out(cnt_q);
						status_q <= hit ? ist_pkg::ST_OK : ist_pkg::ST_MISS;
						case (mode_q)
							ist_pkg::MODE_ADD: begin
								if (hit) begin
									status_q <= ist_pkg::ST_MISS;
								end else if (full) begin
									status_q <= ist_pkg::ST_FULL;
								end else begin
									status_q <= ist_pkg::ST_OK;
									cnt_q    <= cnt_q + 1'b1;
									count_q  <= ist_pkg::count_out(cnt_q + 1'b1);
								end
							end
							ist_pkg::MODE_REMOVE: begin
								if (hit) begin
									// hold the result until the tail has moved down
									sh_q    <= pos_s1 + 1'b1;
									state_q <= S_SHIFT;
									busy_q  <= 1'b1;
									done_q  <= 1'b0;
								end
							end
							ist_pkg::MODE_QUERY: begin
								status_q <= hit ? ist_pkg::ST_OK : ist_pkg::ST_MISS;
							end
							default: begin
								status_q <= ist_pkg::ST_MISS;
							end
						endcase
					end
				end
				S_SHIFT: begin
					vld_s1 <= sh_issue;
					dst_s1 <= sh_q[ist_pkg::ADDR_W-1:0] - 1'b1;
					if (sh_issue) begin
						sh_q <= sh_q + 1'b1;
					end
					if (sh_end) begin
						cnt_q    <= cnt_q - 1'b1;
						count_q  <= ist_pkg::count_out(cnt_q - 1'b1);
						status_q <= ist_pkg::ST_OK;
						done_q   <= 1'b1;
						busy_q   <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	assign busy   = busy_q;
	assign done   = done_q;
	assign status = status_q;
	assign count  = count_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ist_pkg::CNT_W'(ist_pkg::CAPACITY))
		else $error("element count above capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && state_q == S_IDLE))
		else $error("result strobe while request still in progress");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cnt_q == $past(cnt_q) || cnt_q == $past(cnt_q) + 1'b1
			|| cnt_q + 1'b1 == $past(cnt_q)))
		else $error("element count moved by more than one");

	a_cnt_with_done: assert property (@(posedge clk) disable iff (!arst_n)
		##1 (cnt_q != $past(cnt_q)) |-> done_q)
		else $error("element count changed without a result");

	a_shift_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && vld_s1) |-> (dst_s1 < sh_q))
		else $error("shift write not below read address");

endmodule

[design/integer_set_table.sv]
// Integer set table top level: a set of distinct 32-bit values in insertion order.
//
// A request (mode, value) is taken when start is high and busy is low; busy then
// stays high until the result. The result (status, count) is on the ports for a
// single cycle while done is high and cannot be held off, so the receiver must
// capture it then. Entries live in one synchronous RAM read one entry per cycle:
// done rises once the scan has read every entry when the value is not found, once
// it has read the entry at position p when the value is found there, and, for a
// remove that hits, once the entries after p have moved down one place each, the
// tail moving down one entry per cycle as the next entry is read while the
// previous one is written. busy falls with done, so the next request can be
// taken at the edge that ends the result cycle. Up to CAPACITY entries.
module integer_set_table (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [1:0]                         mode,
	input  logic signed [ist_pkg::VALUE_W-1:0] value,
	output logic                               busy,
	output logic                               done,
	output logic [1:0]                         status,
	output logic [ist_pkg::COUNT_W-1:0]        count
);

	ist_pkg::mem_req_t           mem_req;
	logic [ist_pkg::VALUE_W-1:0] rdata;

	ist_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.mode    (mode),
		.value   (value),
		.busy    (busy),
		.done    (done),
		.status  (status),
		.count   (count),
		.mem_req (mem_req),
		.rdata   (rdata)
	);

	ist_ram #(
		.WIDTH (ist_pkg::VALUE_W),
		.DEPTH (ist_pkg::CAPACITY),
		.AW    (ist_pkg::ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.raddr (mem_req.raddr),
		.rdata (rdata)
	);

endmodule

[dv/integer_set_table_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the integer set table: directed table, then random set traffic.
module integer_set_table_tb;

	localparam logic [1:0] MODE_NONE = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 2 * ist_pkg::CAPACITY + 64;
	localparam int MIXED_ITEMS    = 620;

	typedef struct {
		logic [1:0]                  op;
		logic [ist_pkg::VALUE_W-1:0] operand;
		bit                          fixed;
		ist_pkg::status_t            st;
		logic [ist_pkg::COUNT_W-1:0] cnt;
	} table_row_t;

	logic                         clk    = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         start  = 1'b0;
	logic [1:0]                   mode   = ist_pkg::MODE_ADD;
	logic [ist_pkg::VALUE_W-1:0]  value  = '0;
	logic                         busy;
	logic                         done;
	logic [1:0]                   status;
	logic [ist_pkg::COUNT_W-1:0]  count;

	// Predictor state: the elements held, in insertion order
	logic [ist_pkg::VALUE_W-1:0]  held_values[$];
	ist_pkg::status_t             due_status[$];
	logic [ist_pkg::COUNT_W-1:0]  due_count[$];
	table_row_t                   table_rows[$];

	int                           errors          = 0;
	int                           results_checked = 0;
	int                           requests_sent   = 0;
	int                           full_refusals   = 0;
	int                           peak_count      = 0;
	int                           burst_left      = 0;
	int                           idle_cycles     = 0;
	ist_pkg::status_t             exp_st;
	logic [ist_pkg::COUNT_W-1:0]  exp_cnt;

	integer_set_table uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.value  (value),
		.busy   (busy),
		.done   (done),
		.status (status),
		.count  (count)
	);

	always #5 clk = ~clk;

	function automatic int find_held(input logic [ist_pkg::VALUE_W-1:0] v);
		for (int i = 0; i < held_values.size(); i++)
			if (held_values[i] == v)
				return i;
		return -1;
	endfunction

	task automatic set_apply(input logic [1:0] op, input logic [ist_pkg::VALUE_W-1:0] v,
			output ist_pkg::status_t st, output logic [ist_pkg::COUNT_W-1:0] cnt);
		int pos;
		pos = find_held(v);
		st = ist_pkg::ST_MISS;
		case (op)
			ist_pkg::MODE_ADD: begin
				if (pos >= 0)
					st = ist_pkg::ST_MISS;
				else if (held_values.size() >= ist_pkg::CAPACITY) begin
					st = ist_pkg::ST_FULL;
					full_refusals++;
				end else begin
					held_values.push_back(v);
					st = ist_pkg::ST_OK;
				end
			end
			ist_pkg::MODE_REMOVE: begin
				if (pos >= 0) begin
					held_values.delete(pos);
					st = ist_pkg::ST_OK;
				end
			end
			ist_pkg::MODE_QUERY: begin
				if (pos >= 0)
					st = ist_pkg::ST_OK;
			end
			default: ;
		endcase
		if (held_values.size() > peak_count)
			peak_count = held_values.size();
		cnt = ist_pkg::COUNT_W'(held_values.size());
	endtask

	function automatic logic [ist_pkg::VALUE_W-1:0] pick_fresh();
		case ($urandom_range(0, 9))
			0: return ist_pkg::VALUE_W'($urandom_range(0, 15));
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ist_pkg::VALUE_W-1:0] pick_held();
		if (held_values.size() == 0)
			return pick_fresh();
		return held_values[$urandom_range(0, held_values.size() - 1)];
	endfunction

	task automatic add_row(input logic [1:0] op, input logic [ist_pkg::VALUE_W-1:0] v,
			input bit fixed, input ist_pkg::status_t st, input int cnt);
		table_row_t r;
		r.op = op;
		r.operand = v;
		r.fixed = fixed;
		r.st = st;
		r.cnt = ist_pkg::COUNT_W'(cnt);
		table_rows.push_back(r);
	endtask

	// Drive one request, hold it until taken, then record what it should return
	task automatic issue(input logic [1:0] op, input logic [ist_pkg::VALUE_W-1:0] v,
			input bit fixed = 1'b0, input ist_pkg::status_t fst = ist_pkg::ST_OK,
			input logic [ist_pkg::COUNT_W-1:0] fcnt = '0);
		ist_pkg::status_t            st;
		logic [ist_pkg::COUNT_W-1:0] cnt;
		int                          gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 700)
			                                  : $urandom_range(1, 12);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
			                                         : $urandom_range(1, 30);
		end
		burst_left--;
		start <= 1'b1;
		mode  <= op;
		value <= v;
		do @(posedge clk); while (busy !== 1'b0);
		requests_sent++;
		set_apply(op, v, st, cnt);
		due_status.push_back(fixed ? fst : st);
		due_count.push_back(fixed ? fcnt : cnt);
	endtask

	// Hold off until every outstanding request has returned
	task automatic wait_drained();
		start <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (due_status.size() != 0);
	endtask

	task automatic mixed_request(input int add_pct);
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			issue(MODE_NONE, pick_fresh());
		else if (r < 3 + add_pct)
			issue(ist_pkg::MODE_ADD,
			      ($urandom_range(0, 4) == 0) ? pick_held() : pick_fresh());
		else if ($urandom_range(0, 1) == 1)
			issue(ist_pkg::MODE_REMOVE,
			      ($urandom_range(0, 3) != 0) ? pick_held() : pick_fresh());
		else
			issue(ist_pkg::MODE_QUERY,
			      ($urandom_range(0, 1) == 1) ? pick_held() : pick_fresh());
	endtask

	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (due_status.size() == 0) begin
				$error("result with no request pending: status %0d count %0d", status, count);
				errors++;
			end else begin
				exp_st  = due_status.pop_front();
				exp_cnt = due_count.pop_front();
				results_checked++;
				if (status !== exp_st) begin
					$error("status: expected %0d, got %0d", exp_st, status);
					errors++;
				end
				if (count !== exp_cnt) begin
					$error("count: expected %0d, got %0d", exp_cnt, count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int issued;
		int add_pct;
		int round_len;

		add_row(ist_pkg::MODE_QUERY,  32'h0000_0000, 1, ist_pkg::ST_MISS, 0);
		add_row(ist_pkg::MODE_REMOVE, 32'h0000_0000, 1, ist_pkg::ST_MISS, 0);
		add_row(MODE_NONE,            32'hFFFF_FFFF, 1, ist_pkg::ST_MISS, 0);
		add_row(ist_pkg::MODE_ADD,    32'h8000_0000, 1, ist_pkg::ST_OK,   1);
		add_row(ist_pkg::MODE_ADD,    32'h7FFF_FFFF, 1, ist_pkg::ST_OK,   2);
		add_row(ist_pkg::MODE_ADD,    32'h0000_0000, 1, ist_pkg::ST_OK,   3);
		add_row(ist_pkg::MODE_ADD,    32'hFFFF_FFFF, 1, ist_pkg::ST_OK,   4);
		add_row(ist_pkg::MODE_ADD,    32'h8000_0000, 1, ist_pkg::ST_MISS, 4);
		add_row(ist_pkg::MODE_QUERY,  32'h7FFF_FFFF, 1, ist_pkg::ST_OK,   4);
		add_row(ist_pkg::MODE_QUERY,  32'h0000_0001, 1, ist_pkg::ST_MISS, 4);
		add_row(ist_pkg::MODE_REMOVE, 32'h8000_0000, 1, ist_pkg::ST_OK,   3);
		add_row(ist_pkg::MODE_QUERY,  32'h8000_0000, 1, ist_pkg::ST_MISS, 3);
		add_row(ist_pkg::MODE_QUERY,  32'hFFFF_FFFF, 1, ist_pkg::ST_OK,   3);
		add_row(MODE_NONE,            32'h7FFF_FFFF, 1, ist_pkg::ST_MISS, 3);
		add_row(ist_pkg::MODE_ADD,    32'hAAAA_AAAA, 1, ist_pkg::ST_OK,   4);
		add_row(ist_pkg::MODE_ADD,    32'h5555_5555, 1, ist_pkg::ST_OK,   5);
		add_row(ist_pkg::MODE_REMOVE, 32'h5555_5555, 1, ist_pkg::ST_OK,   4);
		add_row(ist_pkg::MODE_REMOVE, 32'h0000_0000, 1, ist_pkg::ST_OK,   3);
		add_row(ist_pkg::MODE_REMOVE, 32'h1234_5678, 1, ist_pkg::ST_MISS, 3);
		add_row(ist_pkg::MODE_ADD,    32'h0000_0001, 0, ist_pkg::ST_OK,   0);
		add_row(ist_pkg::MODE_REMOVE, 32'h7FFF_FFFF, 0, ist_pkg::ST_OK,   0);
		add_row(ist_pkg::MODE_QUERY,  32'hAAAA_AAAA, 0, ist_pkg::ST_OK,   0);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_rows[i])
			issue(table_rows[i].op, table_rows[i].operand, table_rows[i].fixed,
			      table_rows[i].st, table_rows[i].cnt);
		wait_drained();

		// Fill to capacity, then probe the full store
		while (held_values.size() < ist_pkg::CAPACITY)
			issue(ist_pkg::MODE_ADD, pick_fresh());
		repeat (12) begin
			case ($urandom_range(0, 2))
				0: issue(ist_pkg::MODE_ADD, pick_fresh());
				1: issue(ist_pkg::MODE_ADD, pick_held());
				default: issue(ist_pkg::MODE_QUERY, pick_held());
			endcase
		end
		wait_drained();

		issued = 0;
		while (issued < MIXED_ITEMS) begin
			case ($urandom_range(0, 3))
				0: add_pct = 10;
				1: add_pct = 45;
				2: add_pct = 50;
				default: add_pct = 85;
			endcase
			round_len = $urandom_range(30, 120);
			repeat (round_len) mixed_request(add_pct);
			issued += round_len;
			if ($urandom_range(0, 2) == 0)
				wait_drained();
		end

		// Drain to empty, then probe the empty store
		while (held_values.size() > 0)
			issue(ist_pkg::MODE_REMOVE,
			      ($urandom_range(0, 4) == 0) ? pick_fresh() : pick_held());
		issue(ist_pkg::MODE_REMOVE, pick_fresh());
		issue(ist_pkg::MODE_QUERY, pick_fresh());
		issue(MODE_NONE, pick_fresh());

		start <= 1'b0;
		while (due_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (due_status.size() != 0) begin
			$error("%0d requests never returned a result", due_status.size());
			errors++;
		end

		$display("Run covered %0d requests and %0d results; peak occupancy %0d of %0d.",
		         requests_sent, results_checked, peak_count, ist_pkg::CAPACITY);
		$display("Adds refused on a full store: %0d; failures: %0d.", full_refusals, errors);
		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[integer_set_table.f]
design/ist_pkg.sv
design/ist_ram.sv
design/ist_ctrl.sv
design/integer_set_table.sv
dv/integer_set_table_tb.sv
